// File: hw/rtl/e2q_pkg.sv
package e2q_pkg;

  localparam int unsigned ANGLE_BITS_DEF    = 16;
  localparam int unsigned FRACTION_BITS_DEF = 14;

  localparam int unsigned FIELD_W      = 16;
  localparam int unsigned CORDIC_STEPS = 31;
  localparam int unsigned MERGE_STAGES = 5;
  localparam int unsigned LATENCY      = CORDIC_STEPS + MERGE_STAGES;

  // x/y in Q30 with headroom, z with 2^31 = pi/2 plus room for the first step
  localparam int unsigned XY_W = 33;
  localparam int unsigned Z_W  = 34;
  localparam int unsigned PR_W = 2 * XY_W;
  localparam int unsigned SUM_W = PR_W + 1;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [Z_W-1:0]  z_t;

  typedef struct packed {
    xy_t sin_v;
    xy_t cos_v;
  } sc_t;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd1073741824, 32'd633866812, 32'd334917814, 32'd170009512, 32'd85334662,
    32'd42708930, 32'd21359676, 32'd10680490, 32'd5340326, 32'd2670174,
    32'd1335088, 32'd667544, 32'd333772, 32'd166886, 32'd83444,
    32'd41722, 32'd20860, 32'd10430, 32'd5216, 32'd2608,
    32'd1304, 32'd652, 32'd326, 32'd162, 32'd82,
    32'd40, 32'd20, 32'd10, 32'd6, 32'd2, 32'd2
  };

endpackage

// File: hw/rtl/e2q_cordic_lane.sv
module e2q_cordic_lane #(
  parameter int unsigned ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [e2q_pkg::FIELD_W-1:0]   angle_i,
  output e2q_pkg::sc_t                  sc_o
);
  import e2q_pkg::*;

  logic [31:0] ext;
  logic [31:0] turn;
  xy_t x_in [CORDIC_STEPS];
  xy_t y_in [CORDIC_STEPS];
  z_t  z_in [CORDIC_STEPS];
  xy_t x_q  [CORDIC_STEPS];
  xy_t y_q  [CORDIC_STEPS];
  z_t  z_q  [CORDIC_STEPS];

  // keep the low ANGLE_BITS bits and scale so that the half angle has 2^31 = pi/2
  assign ext  = 32'(angle_i);
  assign turn = ext << (32 - ANGLE_BITS);

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    xy_t dx, dy;
    z_t  da;

    if (i == 0) begin : g_first
      assign x_in[i] = CORDIC_GAIN;
      assign y_in[i] = '0;
      assign z_in[i] = Z_W'(signed'(turn));
    end else begin : g_next
      assign x_in[i] = x_q[i-1];
      assign y_in[i] = y_q[i-1];
      assign z_in[i] = z_q[i-1];
    end

    assign dx = y_in[i] >>> i;
    assign dy = x_in[i] >>> i;
    assign da = Z_W'(ATAN_TAB[i]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_in[i][Z_W-1]) begin
          x_q[i] <= x_in[i] - dx;
          y_q[i] <= y_in[i] + dy;
          z_q[i] <= z_in[i] - da;
        end else begin
          x_q[i] <= x_in[i] + dx;
          y_q[i] <= y_in[i] - dy;
          z_q[i] <= z_in[i] + da;
        end
      end
    end
  end

  assign sc_o.sin_v = y_q[CORDIC_STEPS-1];
  assign sc_o.cos_v = x_q[CORDIC_STEPS-1];

endmodule

// File: hw/rtl/e2q_merge.sv
module e2q_merge #(
  parameter int unsigned FRACTION_BITS = e2q_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  e2q_pkg::sc_t                yaw_i,
  input  e2q_pkg::sc_t                pitch_i,
  input  e2q_pkg::sc_t                roll_i,
  output logic [e2q_pkg::FIELD_W-1:0] quat_w_o,
  output logic [e2q_pkg::FIELD_W-1:0] quat_x_o,
  output logic [e2q_pkg::FIELD_W-1:0] quat_y_o,
  output logic [e2q_pkg::FIELD_W-1:0] quat_z_o
);
  import e2q_pkg::*;

  localparam int unsigned SH = 60 - FRACTION_BITS;
  localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) <<< (SH - 1);
  localparam logic signed [SUM_W-1:0] ONE      = SUM_W'(1) <<< FRACTION_BITS;
  localparam logic signed [PR_W-1:0]  HALF_Q30 = PR_W'(1) <<< 29;

  // pair products: cr*cp, sr*sp, sr*cp, cr*sp
  logic signed [PR_W-1:0] pr_q [4];
  xy_t                    yc_q [2];
  xy_t                    ab_q [4];
  xy_t                    yc2_q [2];
  logic signed [PR_W-1:0] tr_q [8];
  logic signed [SUM_W-1:0] sum_q [4];
  logic [FIELD_W-1:0]     res_q [4];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q[0] <= roll_i.cos_v * pitch_i.cos_v;
      pr_q[1] <= roll_i.sin_v * pitch_i.sin_v;
      pr_q[2] <= roll_i.sin_v * pitch_i.cos_v;
      pr_q[3] <= roll_i.cos_v * pitch_i.sin_v;
      yc_q[0] <= yaw_i.cos_v;
      yc_q[1] <= yaw_i.sin_v;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_rnd
    logic signed [PR_W-1:0] rsum;
    assign rsum = pr_q[k] + HALF_Q30;
    always_ff @(posedge clk_i) begin
      if (en_i) ab_q[k] <= rsum[XY_W+29:30];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yc2_q <= yc_q;
      tr_q[0] <= ab_q[0] * yc2_q[0];   // cr cp cy
      tr_q[1] <= ab_q[1] * yc2_q[1];   // sr sp sy
      tr_q[2] <= ab_q[2] * yc2_q[0];   // sr cp cy
      tr_q[3] <= ab_q[3] * yc2_q[1];   // cr sp sy
      tr_q[4] <= ab_q[2] * yc2_q[1];   // sr cp sy
      tr_q[5] <= ab_q[3] * yc2_q[0];   // cr sp cy
      tr_q[6] <= ab_q[0] * yc2_q[1];   // cr cp sy
      tr_q[7] <= ab_q[1] * yc2_q[0];   // sr sp cy
      sum_q[0] <= SUM_W'(tr_q[0]) + SUM_W'(tr_q[1]);
      sum_q[1] <= SUM_W'(tr_q[2]) - SUM_W'(tr_q[3]);
      sum_q[2] <= SUM_W'(tr_q[4]) + SUM_W'(tr_q[5]);
      sum_q[3] <= SUM_W'(tr_q[6]) - SUM_W'(tr_q[7]);
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_fin
    logic signed [SUM_W-1:0] v;
    logic signed [SUM_W-1:0] c;
    assign v = (sum_q[k] + HALF_LSB) >>> SH;
    always_comb begin
      if (v > ONE)       c = ONE;
      else if (v < -ONE) c = -ONE;
      else               c = v;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) res_q[k] <= c[FIELD_W-1:0];
    end
  end

  assign quat_w_o = res_q[0];
  assign quat_x_o = res_q[1];
  assign quat_y_o = res_q[2];
  assign quat_z_o = res_q[3];

endmodule

// File: hw/rtl/euler_to_quaternion.sv
// Channel  Dir  Word                                   Accepted when
// s_axis   in   tdata: yaw[15:0] pitch[31:16] roll[47:32]  s_axis_tvalid_i & s_axis_tready_o
// m_axis   out  tdata: w[15:0] x[31:16] y[47:32] z[63:48]  m_axis_tvalid_o & m_axis_tready_i
//
// One word per cycle while the output is not stalled: 31 CORDIC stages per
// angle lane, then 5 merge stages (pair products, rounding, triple products,
// sums, rounding with saturation into the output register).
// Reset clears only the valid bits of the pipeline.
// A stalled output word holds the whole pipeline; input is taken in the same
// cycle the waiting word leaves.
module euler_to_quaternion #(
  parameter int unsigned ANGLE_BITS    = e2q_pkg::ANGLE_BITS_DEF,
  parameter int unsigned FRACTION_BITS = e2q_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // yaw_angle, pitch_angle, roll_angle
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o    // quat_w, quat_x, quat_y, quat_z
);
  import e2q_pkg::*;

  logic               en;
  logic [LATENCY-1:0] vld_q;
  sc_t                sc_yaw, sc_pitch, sc_roll;
  logic [FIELD_W-1:0] qw, qx, qy, qz;

  // advance unless the output word is waiting and not taken
  assign en              = !vld_q[LATENCY-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LATENCY-2:0], s_axis_tvalid_i};
    end
  end

  // one CORDIC lane per angle
  e2q_cordic_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_yaw (
    .clk_i, .en_i(en), .angle_i(s_axis_tdata_i[15:0]),  .sc_o(sc_yaw)
  );
  e2q_cordic_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_pitch (
    .clk_i, .en_i(en), .angle_i(s_axis_tdata_i[31:16]), .sc_o(sc_pitch)
  );
  e2q_cordic_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_roll (
    .clk_i, .en_i(en), .angle_i(s_axis_tdata_i[47:32]), .sc_o(sc_roll)
  );

  // combine half-angle sines and cosines into the quaternion
  e2q_merge #(.FRACTION_BITS(FRACTION_BITS)) u_merge (
    .clk_i,
    .en_i    (en),
    .yaw_i   (sc_yaw),
    .pitch_i (sc_pitch),
    .roll_i  (sc_roll),
    .quat_w_o(qw),
    .quat_x_o(qx),
    .quat_y_o(qy),
    .quat_z_o(qz)
  );

  assign m_axis_tvalid_o = vld_q[LATENCY-1];
  assign m_axis_tdata_o  = {qz, qy, qx, qw};

endmodule
